[rtl/core/lnsa_pkg.sv]
`timescale 1ns / 1ps
package lnsa_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned N_W      = 7;   // holds a count of up to 64
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned MAG_W    = 23;
  localparam int unsigned SUMSQ_W  = 37;
  localparam int unsigned D2_W     = 44;
  localparam int unsigned NN_W     = 13;
  localparam int unsigned VAR_W    = 48;
  localparam int unsigned DVD_W    = 60;
  localparam int unsigned DVS_W    = 32;
  localparam int unsigned RAD_W    = 64;
  localparam int unsigned ROOT_W   = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_OFFSET = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h1000;
  localparam logic [VAR_W-1:0]  EPS_Q32    = 48'd42950;
  localparam logic [INV_W-1:0]  INV_MAX    = 24'hFFFFFF;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VAR,
    DIV_INV
  } div_sel_e;

  typedef struct packed {
    logic accept;
    logic mean_start;
    logic scan_start;
    logic d2_load;
    logic var_start;
    logic sqrt_start;
    logic inv_start;
    logic emit_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic scan_done;
    logic emit_done;
  } sts_t;

endpackage

[rtl/core/lnsa_ram.sv]
`timescale 1ns / 1ps
module lnsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/lnsa_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module lnsa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lnsa_pkg::DVD_W-1:0]   dividend_i,
  input  logic [lnsa_pkg::DVS_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [lnsa_pkg::DVD_W-1:0]   quotient_o
);

  localparam int unsigned CW = $clog2(lnsa_pkg::DVD_W);

  logic                        run_q, run_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [lnsa_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [lnsa_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [lnsa_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic                        done_q, done_d;
  logic [lnsa_pkg::DVS_W:0]    rem_n;
  logic                        fits;

  assign rem_n = {rem_q, dvd_q[lnsa_pkg::DVD_W-1]};
  assign fits  = rem_n >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      // The quotient bits shift in where the dividend bits leave.
      rem_d = fits ? lnsa_pkg::DVS_W'(rem_n - {1'b0, dvs_q})
                   : rem_n[lnsa_pkg::DVS_W-1:0];
      dvd_d = {dvd_q[lnsa_pkg::DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(lnsa_pkg::DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[rtl/core/lnsa_sqrt.sv]
`timescale 1ns / 1ps
// Integer square root, one root bit per cycle.
module lnsa_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lnsa_pkg::RAD_W-1:0]   radicand_i,
  output logic                         done_o,
  output logic [lnsa_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned CW = $clog2(lnsa_pkg::ROOT_W);

  logic                         run_q, run_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [lnsa_pkg::RAD_W-1:0]   rad_q, rad_d;
  logic [lnsa_pkg::ROOT_W+1:0]  rem_q, rem_d;
  logic [lnsa_pkg::ROOT_W-1:0]  root_q, root_d;
  logic                         done_q, done_d;
  logic [lnsa_pkg::ROOT_W+1:0]  rem_n;
  logic [lnsa_pkg::ROOT_W+1:0]  trial;

  assign rem_n = {rem_q[lnsa_pkg::ROOT_W-1:0], rad_q[lnsa_pkg::RAD_W-1 -: 2]};
  assign trial = {root_q, 2'b01};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (run_q) begin
      rad_d = {rad_q[lnsa_pkg::RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[lnsa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[lnsa_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(lnsa_pkg::ROOT_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/core/lnsa_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: load, mean, sum of squares, variance, root, inverse, emission.
module lnsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               end_of_vector_i,
  input  lnsa_pkg::sts_t     sts_i,
  output lnsa_pkg::cmd_t     cmd_o,
  output logic               busy_o
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_MEAN_GO = 4'd1;
  localparam logic [3:0] S_MEAN_W  = 4'd2;
  localparam logic [3:0] S_SCAN_GO = 4'd3;
  localparam logic [3:0] S_SCAN_W  = 4'd4;
  localparam logic [3:0] S_D2      = 4'd5;
  localparam logic [3:0] S_VAR_GO  = 4'd6;
  localparam logic [3:0] S_VAR_W   = 4'd7;
  localparam logic [3:0] S_SQRT_GO = 4'd8;
  localparam logic [3:0] S_SQRT_W  = 4'd9;
  localparam logic [3:0] S_INV_GO  = 4'd10;
  localparam logic [3:0] S_INV_W   = 4'd11;
  localparam logic [3:0] S_EMIT_GO = 4'd12;
  localparam logic [3:0] S_EMIT_W  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == S_LOAD);
  assign busy_o = state_q != S_LOAD;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      S_LOAD: begin
        if (accept && end_of_vector_i) begin
          state_d = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        cmd_o.mean_start = 1'b1;
        state_d = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (sts_i.div_done) begin
          state_d = S_SCAN_GO;
        end
      end
      S_SCAN_GO: begin
        cmd_o.scan_start = 1'b1;
        state_d = S_SCAN_W;
      end
      S_SCAN_W: begin
        if (sts_i.scan_done) begin
          state_d = S_D2;
        end
      end
      S_D2: begin
        cmd_o.d2_load = 1'b1;
        state_d = S_VAR_GO;
      end
      S_VAR_GO: begin
        cmd_o.var_start = 1'b1;
        state_d = S_VAR_W;
      end
      S_VAR_W: begin
        if (sts_i.div_done) begin
          state_d = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (sts_i.sqrt_done) begin
          state_d = S_INV_GO;
        end
      end
      S_INV_GO: begin
        cmd_o.inv_start = 1'b1;
        state_d = S_INV_W;
      end
      S_INV_W: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT_GO;
        end
      end
      S_EMIT_GO: begin
        cmd_o.emit_start = 1'b1;
        state_d = S_EMIT_W;
      end
      S_EMIT_W: begin
        if (sts_i.emit_done) begin
          cmd_o.finish = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/lnsa_dp.sv]
`timescale 1ns / 1ps
// Datapath: sample store, statistics, shared divider and root, output pipeline.
module lnsa_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lnsa_pkg::cmd_t                           cmd_i,
  output lnsa_pkg::sts_t                           sts_o,
  input  logic signed [lnsa_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                                     cfg_we_i,
  input  logic [lnsa_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [lnsa_pkg::GAIN_W-1:0]              cfg_data_i,
  output logic                                     result_valid_o,
  output logic signed [lnsa_pkg::SAMPLE_W-1:0]     normalized_o,
  output logic                                     final_result_o,
  output logic signed [lnsa_pkg::SAMPLE_W-1:0]     vector_mean_o,
  output logic [lnsa_pkg::INV_W-1:0]               inverse_deviation_o,
  output logic                                     dropped_samples_o
);

  localparam int unsigned AW  = $clog2(MAX_LEN);
  localparam int unsigned CNW = $clog2(MAX_LEN + 1);
  localparam logic signed [58:0] ROUND_HALF = 59'sd1 <<< 27;

  // Configuration.
  logic signed [lnsa_pkg::GAIN_W-1:0] gain_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= lnsa_pkg::GAIN_RESET;
      beta_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lnsa_pkg::REG_SCALE_GAIN) begin
        gain_q <= cfg_data_i;
      end
      if (cfg_index_i == lnsa_pkg::REG_SHIFT_OFFSET) begin
        beta_q <= cfg_data_i;
      end
    end
  end

  // Loading.
  logic [CNW-1:0]                    cnt_q;
  logic signed [lnsa_pkg::SUM_W-1:0] sum_q;
  logic                              ovf_q;
  logic                              room;
  logic                              wr_en;

  assign room  = cnt_q != CNW'(MAX_LEN);
  assign wr_en = cmd_i.accept && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.finish) begin
      cnt_q <= '0;
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (room) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + lnsa_pkg::SUM_W'(sample_i);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // Store read pass, shared by the sum of squares and the emission.
  logic [CNW-1:0]                         rd_cnt_q;
  logic                                   pass_q;
  logic                                   emit_mode_q;
  logic                                   issue_last;
  logic [lnsa_pkg::SAMPLE_W-1:0]          rdata;
  logic                                   p1_v_q, p1_last_q;

  assign issue_last = rd_cnt_q == cnt_q - 1'b1;

  lnsa_ram #(
    .WIDTH (lnsa_pkg::SAMPLE_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (sample_i),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= 1'b0;
      rd_cnt_q    <= '0;
      emit_mode_q <= 1'b0;
      p1_v_q      <= 1'b0;
      p1_last_q   <= 1'b0;
    end else begin
      p1_v_q    <= pass_q;
      p1_last_q <= pass_q && issue_last;
      if (cmd_i.scan_start || cmd_i.emit_start) begin
        pass_q      <= 1'b1;
        rd_cnt_q    <= '0;
        emit_mode_q <= cmd_i.emit_start;
      end else if (pass_q) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
        if (issue_last) begin
          pass_q <= 1'b0;
        end
      end
    end
  end

  // Mean and squares.
  logic [lnsa_pkg::MAG_W-1:0]          mag;
  logic [lnsa_pkg::N_W-1:0]            n;
  logic signed [lnsa_pkg::SAMPLE_W-1:0] mean_q;
  logic [lnsa_pkg::D2_W-1:0]           magsq_q;
  logic [lnsa_pkg::NN_W-1:0]           nn_q;
  logic signed [31:0]                  sq;
  logic [30:0]                         sq_q;
  logic                                s2_v_q, s2_last_q;
  logic [lnsa_pkg::SUMSQ_W-1:0]        sumsq_q;
  logic                                scan_done_q;
  logic [lnsa_pkg::D2_W-1:0]           nsumsq;
  logic [lnsa_pkg::D2_W-1:0]           d2_q;
  logic [lnsa_pkg::VAR_W-1:0]          var_q;

  assign n      = lnsa_pkg::N_W'(cnt_q);
  assign mag    = sum_q[lnsa_pkg::SUM_W-1] ? lnsa_pkg::MAG_W'(-sum_q)
                                           : lnsa_pkg::MAG_W'(sum_q);
  assign sq     = $signed(rdata) * $signed(rdata);
  assign nsumsq = lnsa_pkg::D2_W'(n) * lnsa_pkg::D2_W'(sumsq_q);

  // Shared divider and root.
  logic                           div_start, div_done;
  logic [lnsa_pkg::DVD_W-1:0]     dvd, quot;
  logic [lnsa_pkg::DVS_W-1:0]     dvs;
  lnsa_pkg::div_sel_e             div_sel_q;
  logic                           sqrt_done;
  logic [lnsa_pkg::ROOT_W-1:0]    root;
  logic [lnsa_pkg::INV_W-1:0]     inv_q;
  logic [16:0]                    q_mean;

  assign div_start = cmd_i.mean_start || cmd_i.var_start || cmd_i.inv_start;

  always_comb begin
    if (cmd_i.mean_start) begin
      dvd = lnsa_pkg::DVD_W'({mag, 1'b0} + lnsa_pkg::DVD_W'(n));
      dvs = lnsa_pkg::DVS_W'({n, 1'b0});
    end else if (cmd_i.var_start) begin
      dvd = lnsa_pkg::DVD_W'({d2_q, 16'h0000});
      dvs = lnsa_pkg::DVS_W'(nn_q);
    end else begin
      dvd = lnsa_pkg::DVD_W'(64'd1 << 40);
      dvs = root;
    end
  end

  lnsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  lnsa_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i ({var_q + lnsa_pkg::EPS_Q32, 16'h0000}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign q_mean = quot[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_sel_q   <= lnsa_pkg::DIV_MEAN;
      s2_v_q      <= 1'b0;
      s2_last_q   <= 1'b0;
      scan_done_q <= 1'b0;
    end else begin
      if (cmd_i.mean_start) begin
        div_sel_q <= lnsa_pkg::DIV_MEAN;
      end else if (cmd_i.var_start) begin
        div_sel_q <= lnsa_pkg::DIV_VAR;
      end else if (cmd_i.inv_start) begin
        div_sel_q <= lnsa_pkg::DIV_INV;
      end
      s2_v_q      <= p1_v_q;
      s2_last_q   <= p1_last_q;
      scan_done_q <= s2_v_q && s2_last_q && !emit_mode_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_start) begin
      magsq_q <= lnsa_pkg::D2_W'(mag) * lnsa_pkg::D2_W'(mag);
      nn_q    <= lnsa_pkg::NN_W'(n) * lnsa_pkg::NN_W'(n);
    end
    if (cmd_i.scan_start) begin
      sumsq_q <= '0;
    end else if (s2_v_q && !emit_mode_q) begin
      sumsq_q <= sumsq_q + lnsa_pkg::SUMSQ_W'(sq_q);
    end
    sq_q <= sq[30:0];
    if (cmd_i.d2_load) begin
      d2_q <= nsumsq - magsq_q;
    end
    if (div_done) begin
      unique case (div_sel_q)
        lnsa_pkg::DIV_MEAN: begin
          mean_q <= sum_q[lnsa_pkg::SUM_W-1] ? lnsa_pkg::SAMPLE_W'(-q_mean)
                                             : lnsa_pkg::SAMPLE_W'(q_mean);
        end
        lnsa_pkg::DIV_VAR: begin
          var_q <= quot[lnsa_pkg::VAR_W-1:0];
        end
        lnsa_pkg::DIV_INV: begin
          inv_q <= (quot > lnsa_pkg::DVD_W'(lnsa_pkg::INV_MAX)) ? lnsa_pkg::INV_MAX
                                                             : quot[lnsa_pkg::INV_W-1:0];
        end
        default: begin
          inv_q <= lnsa_pkg::INV_MAX;
        end
      endcase
    end
  end

  // Emission pipeline: difference times inverse, times gain, offset and round.
  logic signed [16:0] diff;
  logic signed [41:0] prod1, prod1_q;
  logic signed [57:0] prod2_q;
  logic signed [58:0] t;
  logic signed [30:0] y;
  logic               s3_v_q, s3_last_q;
  logic               res_v_q, res_last_q;
  logic signed [lnsa_pkg::SAMPLE_W-1:0] res_q;

  assign diff  = 17'($signed(rdata)) - 17'(mean_q);
  assign prod1 = diff * $signed({1'b0, inv_q});
  assign t     = 59'(prod2_q) + (59'(beta_q) <<< 24) + ROUND_HALF;
  assign y     = t[58:28];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q     <= 1'b0;
      s3_last_q  <= 1'b0;
      res_v_q    <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      s3_v_q     <= s2_v_q && emit_mode_q;
      s3_last_q  <= s2_last_q;
      res_v_q    <= s3_v_q;
      res_last_q <= s3_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= prod1;
    prod2_q <= prod1_q * gain_q;
    if (y > 31'sd32767) begin
      res_q <= 16'sh7FFF;
    end else if (y < -31'sd32768) begin
      res_q <= 16'sh8000;
    end else begin
      res_q <= y[lnsa_pkg::SAMPLE_W-1:0];
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.scan_done = scan_done_q;
  assign sts_o.emit_done = res_v_q && res_last_q;

  assign result_valid_o      = res_v_q;
  assign normalized_o        = res_q;
  assign final_result_o      = res_v_q && res_last_q;
  assign vector_mean_o       = mean_q;
  assign inverse_deviation_o = inv_q;
  assign dropped_samples_o   = ovf_q;

endmodule

[rtl/core/layer_norm_scalar_affine_top.sv]
`timescale 1ns / 1ps
// Layer normalization with a scalar gain and offset.
//
// Input words: raise start_i with sample_i and end_of_vector_i; a word is taken
// at a rising edge where start_i is high and busy_o is low. While a vector is
// loading the block takes one word per cycle. Up to MAX_LEN samples are kept;
// further samples are dropped and flagged on dropped_samples_o.
// When the word with end_of_vector_i arrives, busy_o rises and the block
// computes the mean in the divider, walks the store for the sum of squares,
// forms the variance in the divider, the square root in the root unit and
// its inverse in the divider, then walks the store again and emits one result
// word per stored sample, one per cycle, after a four-stage pipeline.
// Each result word is shown for exactly one cycle with result_valid_o high;
// the receiver cannot stall, so it must take every word as it comes.
// busy_o falls after the final result, marked by final_result_o.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are taken at once
// and should only happen while the block is idle.
// Reset clears the counters, the flags and the registers to gain 1.0, offset 0.
module layer_norm_scalar_affine_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [lnsa_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 end_of_vector_i,
  input  logic                                 cfg_we_i,
  input  logic [lnsa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lnsa_pkg::GAIN_W-1:0]          cfg_data_i,
  output logic                                 result_valid_o,
  output logic signed [lnsa_pkg::SAMPLE_W-1:0] normalized_o,
  output logic                                 final_result_o,
  output logic signed [lnsa_pkg::SAMPLE_W-1:0] vector_mean_o,
  output logic [lnsa_pkg::INV_W-1:0]           inverse_deviation_o,
  output logic                                 dropped_samples_o
);

  // The controller sequences the phases; the datapath reports completion.
  lnsa_pkg::cmd_t cmd;
  lnsa_pkg::sts_t sts;

  lnsa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .end_of_vector_i (end_of_vector_i),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .busy_o          (busy_o)
  );

  lnsa_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_i            (sample_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .normalized_o        (normalized_o),
    .final_result_o      (final_result_o),
    .vector_mean_o       (vector_mean_o),
    .inverse_deviation_o (inverse_deviation_o),
    .dropped_samples_o   (dropped_samples_o)
  );

endmodule

[rtl/core/lnsa_checker.sv]
`timescale 1ns / 1ps
module lnsa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic end_of_vector_i,
  input logic result_valid_o,
  input logic final_result_o
);

  // Results only appear while a vector is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result word outside a busy phase");

  // The word that ends a vector starts processing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && end_of_vector_i) |=> busy_o)
    else $error("end of vector did not start processing");

  // Loading continues after any other word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !end_of_vector_i) |=> !busy_o)
    else $error("block went busy in the middle of a vector");

  // The final result ends the emission.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && final_result_o) |=> (!result_valid_o && !busy_o))
    else $error("activity after the final result");

endmodule

bind layer_norm_scalar_affine_top lnsa_checker u_lnsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .end_of_vector_i (end_of_vector_i),
  .result_valid_o  (result_valid_o),
  .final_result_o  (final_result_o)
);
